// File: sv/msat_pkg.sv
// ----------------------------------------------------------------------------
// msat_pkg - shared definitions for the multi-slot alarm timer
// Field widths, command and event codes, and the shared arithmetic unit's
// request and response types.
// ----------------------------------------------------------------------------
package msat_pkg;

  // Field widths
  localparam int CMD_W    = 3;
  localparam int TIME_W   = 64;
  localparam int DELAY_W  = 32;
  localparam int SLOT_W   = 4;
  localparam int KIND_W   = 3;
  localparam int PERIOD_W = 42;

  // Defaults and fixed limits
  localparam int TIMER_SLOTS_DEF = 16;
  localparam int MAX_FIRES       = 16;
  localparam int US_PER_MS       = 1000;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ARM_ABS = 3'd1;
  localparam logic [CMD_W-1:0] CMD_ARM_DLY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ARM_PER = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CANCEL  = 3'd4;

  // Event codes
  localparam logic [KIND_W-1:0] EV_ARMED     = 3'd0;
  localparam logic [KIND_W-1:0] EV_FIRED     = 3'd1;
  localparam logic [KIND_W-1:0] EV_CANCELLED = 3'd2;
  localparam logic [KIND_W-1:0] EV_FULL      = 3'd3;
  localparam logic [KIND_W-1:0] EV_NOT_ARMED = 3'd4;

  // Shared compare / saturating add unit
  typedef struct packed {
    logic [TIME_W-1:0] a;
    logic [TIME_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic              lt;   // a < b
    logic [TIME_W-1:0] sum;  // a + b, saturated
  } alu_rsp_t;

endpackage

// File: sv/msat_if.sv
// ----------------------------------------------------------------------------
// msat_if - channel interfaces of the multi-slot alarm timer
// Command channel and event channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface msat_in_if;
  logic                               valid;
  logic                               ready;
  logic [msat_pkg::CMD_W-1:0]         command;
  logic [msat_pkg::TIME_W-1:0]        now_us;
  logic [msat_pkg::TIME_W-1:0]        target_time_us;
  logic [msat_pkg::DELAY_W-1:0]       delay_ms;
  logic [msat_pkg::SLOT_W-1:0]        slot_to_cancel;

  modport source (output valid, command, now_us, target_time_us, delay_ms,
                  slot_to_cancel, input ready);
  modport sink   (input valid, command, now_us, target_time_us, delay_ms,
                  slot_to_cancel, output ready);
endinterface

interface msat_out_if;
  logic                        valid;
  logic                        ready;
  logic [msat_pkg::KIND_W-1:0] event_kind;
  logic [msat_pkg::SLOT_W-1:0] slot_id;
  logic                        last_of_run;

  modport source (output valid, event_kind, slot_id, last_of_run, input ready);
  modport sink   (input valid, event_kind, slot_id, last_of_run, output ready);
endinterface

// File: sv/msat_ram.sv
// ----------------------------------------------------------------------------
// msat_ram - slot table memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module msat_ram #(
  parameter int DEPTH = msat_pkg::TIMER_SLOTS_DEF,
  parameter int WIDTH = msat_pkg::TIME_W
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: sv/msat_alu.sv
// ----------------------------------------------------------------------------
// msat_alu - shared 64-bit compare and saturating add
// One magnitude compare and one adder, used by the find, due, pick and fire steps.
// ----------------------------------------------------------------------------
module msat_alu (
  input  msat_pkg::alu_req_t req,
  output msat_pkg::alu_rsp_t rsp
);

  logic [msat_pkg::TIME_W:0] sum_full;

  // unsigned compare
  assign rsp.lt = (req.a < req.b);

  // add with saturation at all ones
  assign sum_full = {1'b0, req.a} + {1'b0, req.b};
  assign rsp.sum  = sum_full[msat_pkg::TIME_W] ? '1 : sum_full[msat_pkg::TIME_W-1:0];

endmodule

// File: sv/multi_slot_alarm_timer.sv
// ----------------------------------------------------------------------------
// multi_slot_alarm_timer - table of one-shot and periodic alarm slots
//
//   channel | dir | payload                                            | transfer
//   in_ch   | in  | command, now_us, target_time_us, delay_ms,         | valid & ready
//           |     | slot_to_cancel                                     |
//   out_ch  | out | event_kind, slot_id, last_of_run                   | valid & ready
//
// One command at a time; in_ch.ready is high only while the sequencer idles.
// Cancel is decided at decode; arm walks the N slots for the lowest free one
// and reports the table full when none is free.
// Tick: one scan marks due slots, then one scan per fire picks the next,
// each a serial walk through the expiry memory's single read port.
// Synchronous active-low reset clears all slots; a stalled out_ch holds
// the sequencer in its emit step.
// ----------------------------------------------------------------------------
module multi_slot_alarm_timer #(
  parameter int TIMER_SLOTS = msat_pkg::TIMER_SLOTS_DEF
) (
  input logic              clk,
  input logic              rst_n,
  msat_in_if.sink          in_ch,
  msat_out_if.source       out_ch
);

  localparam int N  = TIMER_SLOTS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam int CW = $clog2(N + 1);
  localparam int FW = $clog2(msat_pkg::MAX_FIRES);
  localparam int PW = msat_pkg::PERIOD_W + 1;
  localparam int TW = msat_pkg::TIME_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_FIND, S_DUE, S_PICK, S_PDEC, S_FIRE, S_EMIT
  } state_t;

  // control
  state_t                          state_r,     state_nxt;
  state_t                          after_r,     after_nxt;
  logic [CW-1:0]                   cnt_r,       cnt_nxt;
  logic [N-1:0]                    armed_r,     armed_nxt;
  logic [N-1:0]                    due_r,       due_nxt;
  logic                            have_r,      have_nxt;
  logic [FW-1:0]                   fires_r,     fires_nxt;
  logic                            out_valid_r, out_valid_nxt;

  // payload
  logic [msat_pkg::CMD_W-1:0]      cmd_r,       cmd_nxt;
  logic [TW-1:0]                   now_r,       now_nxt;
  logic [TW-1:0]                   target_r,    target_nxt;
  logic [msat_pkg::DELAY_W-1:0]    delay_r,     delay_nxt;
  logic [msat_pkg::SLOT_W-1:0]     victim_r,    victim_nxt;
  logic [msat_pkg::PERIOD_W-1:0]   dly_us_r,    dly_us_nxt;
  logic [IW-1:0]                   best_r,      best_nxt;
  logic [TW-1:0]                   best_exp_r,  best_exp_nxt;
  logic [msat_pkg::KIND_W-1:0]     res_kind_r,  res_kind_nxt;
  logic [msat_pkg::SLOT_W-1:0]     res_slot_r,  res_slot_nxt;
  logic                            res_last_r,  res_last_nxt;
  logic [msat_pkg::KIND_W-1:0]     out_kind_r,  out_kind_nxt;
  logic [msat_pkg::SLOT_W-1:0]     out_slot_r,  out_slot_nxt;
  logic                            out_last_r,  out_last_nxt;

  // memories and shared unit
  logic                            exp_we;
  logic [IW-1:0]                   exp_waddr;
  logic [TW-1:0]                   exp_wdata;
  logic [TW-1:0]                   exp_q;
  logic                            per_we;
  logic [PW-1:0]                   per_wdata;
  logic [PW-1:0]                   per_q;
  msat_pkg::alu_req_t              alu_req;
  msat_pkg::alu_rsp_t              alu_rsp;

  // helpers
  logic                            out_free;
  logic                            scan_end;
  logic [IW-1:0]                   scan_idx;
  logic [IW-1:0]                   proc_idx;
  logic [IW-1:0]                   victim_idx;
  logic                            victim_ok;
  logic [msat_pkg::PERIOD_W-1:0]   dly_eff;
  logic [msat_pkg::PERIOD_W-1:0]   per_eff;
  logic [N-1:0]                    best_mask;
  logic                            more_due;
  logic                            fire_last;

  msat_ram #(.DEPTH(N), .WIDTH(TW)) u_exp_ram (
    .clk   (clk),
    .we    (exp_we),
    .waddr (exp_waddr),
    .wdata (exp_wdata),
    .raddr (scan_idx),
    .rdata (exp_q)
  );

  msat_ram #(.DEPTH(N), .WIDTH(PW)) u_per_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (scan_idx),
    .wdata (per_wdata),
    .raddr (best_r),
    .rdata (per_q)
  );

  msat_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // handshake and helper terms
  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.event_kind  = out_kind_r;
  assign out_ch.slot_id     = out_slot_r;
  assign out_ch.last_of_run = out_last_r;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign scan_end   = (cnt_r == CW'(N));
  assign scan_idx   = cnt_r[IW-1:0];
  assign proc_idx   = IW'(cnt_r - CW'(1));
  assign victim_idx = IW'(victim_r);
  assign victim_ok  = (int'(victim_r) < N) && armed_r[victim_idx];
  assign dly_eff    = (dly_us_r == '0) ? msat_pkg::PERIOD_W'(1) : dly_us_r;
  assign per_eff    = (per_q[PW-2:0] == '0) ? msat_pkg::PERIOD_W'(1) : per_q[PW-2:0];
  assign best_mask  = N'(1) << best_r;
  assign more_due   = |(due_r & ~best_mask);
  assign fire_last  = !more_due || (fires_r == FW'(msat_pkg::MAX_FIRES - 1));

  // shared unit operand select
  always_comb begin
    alu_req.a = now_r;
    alu_req.b = exp_q;
    unique case (state_r)
      S_FIND:  alu_req.b = TW'(dly_us_r);
      S_PICK: begin
        alu_req.a = exp_q;
        alu_req.b = best_exp_r;
      end
      S_FIRE:  alu_req.b = TW'(per_eff);
      default: alu_req.b = exp_q;
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt     = state_r;
    after_nxt     = after_r;
    cnt_nxt       = cnt_r;
    armed_nxt     = armed_r;
    due_nxt       = due_r;
    have_nxt      = have_r;
    fires_nxt     = fires_r;
    cmd_nxt       = cmd_r;
    now_nxt       = now_r;
    target_nxt    = target_r;
    delay_nxt     = delay_r;
    victim_nxt    = victim_r;
    dly_us_nxt    = dly_us_r;
    best_nxt      = best_r;
    best_exp_nxt  = best_exp_r;
    res_kind_nxt  = res_kind_r;
    res_slot_nxt  = res_slot_r;
    res_last_nxt  = res_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_last_nxt  = out_last_r;
    exp_we        = 1'b0;
    exp_waddr     = scan_idx;
    exp_wdata     = alu_rsp.sum;
    per_we        = 1'b0;
    per_wdata     = {(cmd_r == msat_pkg::CMD_ARM_PER),
                     (cmd_r == msat_pkg::CMD_ARM_PER) ? dly_eff : '0};

    unique case (state_r)
      // capture the command transfer
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt    = in_ch.command;
          now_nxt    = in_ch.now_us;
          target_nxt = in_ch.target_time_us;
          delay_nxt  = in_ch.delay_ms;
          victim_nxt = in_ch.slot_to_cancel;
          state_nxt  = S_DECODE;
        end
      end

      // scale the delay, dispatch on command
      S_DECODE: begin
        dly_us_nxt = msat_pkg::PERIOD_W'(delay_r) *
                     msat_pkg::PERIOD_W'(msat_pkg::US_PER_MS);
        cnt_nxt    = '0;
        have_nxt   = 1'b0;
        fires_nxt  = '0;
        after_nxt  = S_IDLE;
        if (cmd_r == msat_pkg::CMD_TICK) begin
          state_nxt = S_DUE;
        end else if (cmd_r == msat_pkg::CMD_ARM_ABS || cmd_r == msat_pkg::CMD_ARM_DLY ||
                     cmd_r == msat_pkg::CMD_ARM_PER) begin
          state_nxt = S_FIND;
        end else if (cmd_r == msat_pkg::CMD_CANCEL) begin
          // event carries the requested slot number as given
          res_slot_nxt = victim_r;
          res_last_nxt = 1'b1;
          if (victim_ok) begin
            armed_nxt[victim_idx] = 1'b0;
            res_kind_nxt          = msat_pkg::EV_CANCELLED;
          end else begin
            res_kind_nxt          = msat_pkg::EV_NOT_ARMED;
          end
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      // walk for the lowest free slot and fill it
      S_FIND: begin
        res_last_nxt = 1'b1;
        if (scan_end) begin
          res_kind_nxt = msat_pkg::EV_FULL;
          res_slot_nxt = '0;
          state_nxt    = S_EMIT;
        end else if (!armed_r[scan_idx]) begin
          exp_we              = 1'b1;
          exp_wdata           = (cmd_r == msat_pkg::CMD_ARM_ABS) ? target_r : alu_rsp.sum;
          per_we              = 1'b1;
          armed_nxt[scan_idx] = 1'b1;
          res_kind_nxt        = msat_pkg::EV_ARMED;
          res_slot_nxt        = msat_pkg::SLOT_W'(scan_idx);
          state_nxt           = S_EMIT;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // fix the due set: armed and expiry <= now
      S_DUE: begin
        if (cnt_r != '0) begin
          due_nxt[proc_idx] = armed_r[proc_idx] && !alu_rsp.lt;
        end
        if (scan_end) begin
          cnt_nxt   = '0;
          have_nxt  = 1'b0;
          state_nxt = S_PICK;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // earliest due expiry, strict compare keeps the lower slot on ties
      S_PICK: begin
        if (cnt_r != '0 && due_r[proc_idx] && (!have_r || alu_rsp.lt)) begin
          have_nxt     = 1'b1;
          best_nxt     = proc_idx;
          best_exp_nxt = exp_q;
        end
        if (scan_end) begin
          state_nxt = S_PDEC;
        end else begin
          cnt_nxt = cnt_r + CW'(1);
        end
      end

      // period read of the chosen slot is in flight
      S_PDEC: begin
        state_nxt = have_r ? S_FIRE : S_IDLE;
      end

      // re-arm or free the chosen slot, queue its event
      S_FIRE: begin
        if (per_q[PW-1]) begin
          exp_we    = 1'b1;
          exp_waddr = best_r;
          exp_wdata = alu_rsp.sum;
        end else begin
          armed_nxt[best_r] = 1'b0;
        end
        due_nxt[best_r] = 1'b0;
        fires_nxt       = fires_r + FW'(1);
        res_kind_nxt    = msat_pkg::EV_FIRED;
        res_slot_nxt    = msat_pkg::SLOT_W'(best_r);
        res_last_nxt    = fire_last;
        after_nxt       = fire_last ? S_IDLE : S_PICK;
        cnt_nxt         = '0;
        have_nxt        = 1'b0;
        state_nxt       = S_EMIT;
      end

      // hand the event to the output register once it is free
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = res_kind_r;
          out_slot_nxt  = res_slot_r;
          out_last_nxt  = res_last_r;
          state_nxt     = after_r;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      after_r     <= S_IDLE;
      cnt_r       <= '0;
      armed_r     <= '0;
      due_r       <= '0;
      have_r      <= 1'b0;
      fires_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      after_r     <= after_nxt;
      cnt_r       <= cnt_nxt;
      armed_r     <= armed_nxt;
      due_r       <= due_nxt;
      have_r      <= have_nxt;
      fires_r     <= fires_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    now_r      <= now_nxt;
    target_r   <= target_nxt;
    delay_r    <= delay_nxt;
    victim_r   <= victim_nxt;
    dly_us_r   <= dly_us_nxt;
    best_r     <= best_nxt;
    best_exp_r <= best_exp_nxt;
    res_kind_r <= res_kind_nxt;
    res_slot_r <= res_slot_nxt;
    res_last_r <= res_last_nxt;
    out_kind_r <= out_kind_nxt;
    out_slot_r <= out_slot_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef NO_ASSERTIONS
  // a fire always has a chosen slot that is due and armed
  a_fire_has_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIRE) |-> (have_r && due_r[best_r] && armed_r[best_r]))
    else $error("fire step without a due armed slot");

  // only a fire can be followed by more events of the same command
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != msat_pkg::EV_FIRED) |-> out_last_r)
    else $error("non-fire event without last mark");

  // a blocked output keeps the sequencer in its emit step
  a_emit_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_valid_r && !out_ch.ready) |=> (state_r == S_EMIT))
    else $error("emit step left while output stalled");

  // after a last event the block returns to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free && res_last_r) |=> (state_r == S_IDLE))
    else $error("last event not followed by idle");
`endif

endmodule
